### hdl/rmth_pkg.sv
// ----------------------------------------------------------------------------
// rmth_pkg: shared types and constants for the running median block
// Sizes, datapath command codes, controller states and heap ordering helper.
// ----------------------------------------------------------------------------
package rmth_pkg;

	localparam int HEAP_DEPTH = 512;
	localparam int VALUE_BITS = 32;
	localparam int MED_BITS   = VALUE_BITS + 1;
	localparam int IDX_W      = $clog2(HEAP_DEPTH);
	localparam int CNT_W      = IDX_W + 1;

	typedef logic signed [VALUE_BITS-1:0] value_t;
	typedef logic signed [MED_BITS-1:0]   med_t;
	typedef logic [IDX_W-1:0]             idx_t;
	typedef logic [CNT_W-1:0]             cnt_t;

	localparam logic HEAP_LO = 1'b0;
	localparam logic HEAP_HI = 1'b1;

	typedef enum logic [3:0] {
		DP_NOP,
		DP_LOAD,
		DP_PUSH_INIT,
		DP_PUSH_RD,
		DP_PUSH_CMP,
		DP_POP_INIT,
		DP_POP_LAST,
		DP_POP_RD,
		DP_POP_CMP,
		DP_FIN
	} dp_op_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_OP_START,
		ST_PUSH_RD,
		ST_PUSH_CMP,
		ST_POP_LAST,
		ST_POP_RD,
		ST_POP_CMP,
		ST_FIN
	} ctl_state_t;

	typedef struct packed {
		dp_op_t op;
		logic   heap;
		logic   from_v;
		logic   med_eq;
		logic   drop;
	} dp_cmd_t;

	typedef struct packed {
		logic above;
		logic cnt_eq;
		logic lo_gt;
		logic full;
		logic k_zero;
		logic up_move;
		logic n_zero;
		logic c_out;
		logic dn_move;
	} dp_status_t;

	// one heap operation of an item plan
	typedef struct packed {
		logic pop;
		logic heap;
		logic from_v;
	} heap_op_t;

	// true if a belongs above b: lower heap keeps its maximum on top
	function automatic logic hp_above(logic heap, value_t a, value_t b);
		hp_above = (heap == HEAP_LO) ? (a > b) : (a < b);
	endfunction

endpackage

### hdl/rmth_sample_if.sv
// ----------------------------------------------------------------------------
// rmth_sample_if: input channel
// Valid/ready channel carrying one signed sample per item.
// ----------------------------------------------------------------------------
interface rmth_sample_if;
	import rmth_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;

	modport source (output valid, output value, input ready);
	modport sink (input valid, input value, output ready);
endinterface

### hdl/rmth_result_if.sv
// ----------------------------------------------------------------------------
// rmth_result_if: result channel
// Valid/ready channel carrying twice the median and the drop flag.
// ----------------------------------------------------------------------------
interface rmth_result_if;
	import rmth_pkg::*;

	logic valid;
	logic ready;
	med_t median_x2;
	logic dropped;

	modport source (output valid, output median_x2, output dropped, input ready);
	modport sink (input valid, input median_x2, input dropped, output ready);
endinterface

### hdl/running_median_two_heaps.sv
// A push climbs and a pop sinks the heap level by level (at depth 512 a push
// climbs at most 9 levels and a pop sinks at most 8); a rebalancing item runs
// a pop and two pushes, and a dropped item runs no heap operation.
// Throughput: one item at a time; the next is taken once the result is staged.
// Reset (arst_n, asynchronous): counts and median clear, heap memories stay
// unwritten; no clearing pass.
// ----------------------------------------------------------------------------
// running_median_two_heaps: running median over two heaps
// Returns twice the median of all kept samples, one result per sample.
// ----------------------------------------------------------------------------
module running_median_two_heaps (
	input  logic          clk,
	input  logic          arst_n,
	rmth_sample_if.sink   sample,
	rmth_result_if.source result
);
	import rmth_pkg::*;

	dp_cmd_t    cmd;
	dp_status_t status;

	rmth_ctrl u_ctrl (
		.clk          (clk),
		.arst_n       (arst_n),
		.sample_valid (sample.valid),
		.sample_ready (sample.ready),
		.result_valid (result.valid),
		.result_ready (result.ready),
		.cmd          (cmd),
		.status       (status)
	);

	rmth_dp u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.status    (status),
		.value     (sample.value),
		.median_x2 (result.median_x2),
		.dropped   (result.dropped)
	);
endmodule

### hdl/rmth_dp.sv
// ----------------------------------------------------------------------------
// rmth_dp: heap datapath
// Two heap memories with cached tops, counts, sift index registers and the
// doubled median register. Acts on one command from the controller a cycle.
// ----------------------------------------------------------------------------
module rmth_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  rmth_pkg::dp_cmd_t   cmd,
	output rmth_pkg::dp_status_t status,
	input  rmth_pkg::value_t    value,
	output rmth_pkg::med_t      median_x2,
	output logic                dropped
);
	import rmth_pkg::*;

	value_t mem_lo [HEAP_DEPTH];
	value_t mem_hi [HEAP_DEPTH];

	value_t v_q, pv_q, last_q;
	value_t top_q [2];
	cnt_t   cnt_q [2];
	med_t   med_q;
	logic   drop_q;
	idx_t   k_q, n_q;
	value_t rd_lo_a_q, rd_lo_b_q, rd_hi_a_q, rd_hi_b_q;

	value_t rda, rdb, child;
	idx_t   parent, ra, rb, child_idx;
	cnt_t   c_idx, c1_idx, cnt_sel, cnt_m1;
	logic   b_ok, use_b;
	logic   wr_en;
	idx_t   wr_addr;
	value_t wr_data;
	med_t   med_next;

	assign rda     = (cmd.heap == HEAP_HI) ? rd_hi_a_q : rd_lo_a_q;
	assign rdb     = (cmd.heap == HEAP_HI) ? rd_hi_b_q : rd_lo_b_q;
	assign cnt_sel = cnt_q[cmd.heap];
	assign cnt_m1  = cnt_sel - 1'b1;
	assign parent  = IDX_W'((k_q - 1'b1) >> 1);
	assign c_idx   = {k_q, 1'b1};
	assign c1_idx  = c_idx + 1'b1;
	assign b_ok    = c1_idx < {1'b0, n_q};
	assign use_b   = b_ok && hp_above(cmd.heap, rdb, rda);
	assign child   = use_b ? rdb : rda;
	assign child_idx = use_b ? c1_idx[IDX_W-1:0] : c_idx[IDX_W-1:0];

	always_comb begin
		status.above   = $signed({v_q, 1'b0}) > med_q;
		status.cnt_eq  = cnt_q[HEAP_LO] == cnt_q[HEAP_HI];
		status.lo_gt   = cnt_q[HEAP_LO] > cnt_q[HEAP_HI];
		status.full    = (cnt_q[HEAP_LO] == CNT_W'(HEAP_DEPTH)) &&
			(cnt_q[HEAP_HI] == CNT_W'(HEAP_DEPTH));
		status.k_zero  = k_q == '0;
		status.up_move = hp_above(cmd.heap, pv_q, rda);
		status.n_zero  = cnt_sel == CNT_W'(1);
		status.c_out   = c_idx >= {1'b0, n_q};
		status.dn_move = hp_above(cmd.heap, child, last_q);
	end

	always_comb begin
		ra      = parent;
		rb      = c1_idx[IDX_W-1:0];
		wr_en   = 1'b0;
		wr_addr = k_q;
		wr_data = pv_q;
		unique case (cmd.op)
			DP_POP_INIT: ra = cnt_m1[IDX_W-1:0];
			DP_POP_RD: begin
				ra = c_idx[IDX_W-1:0];
				if (status.c_out) begin
					wr_en   = 1'b1;
					wr_data = last_q;
				end
			end
			DP_PUSH_RD: wr_en = status.k_zero;
			DP_PUSH_CMP: begin
				wr_en = 1'b1;
				if (status.up_move)
					wr_data = rda;
			end
			DP_POP_CMP: begin
				wr_en   = 1'b1;
				wr_data = status.dn_move ? child : last_q;
			end
			default: ;
		endcase
	end

	always_comb begin
		if (cmd.drop)
			med_next = med_q;
		else if (cmd.med_eq)
			med_next = {top_q[cmd.heap], 1'b0};
		else
			med_next = {top_q[HEAP_LO][VALUE_BITS-1], top_q[HEAP_LO]} +
				{top_q[HEAP_HI][VALUE_BITS-1], top_q[HEAP_HI]};
	end

	always_ff @(posedge clk) begin
		if (wr_en && cmd.heap == HEAP_LO)
			mem_lo[wr_addr] <= wr_data;
		if (wr_en && cmd.heap == HEAP_HI)
			mem_hi[wr_addr] <= wr_data;
		rd_lo_a_q <= mem_lo[ra];
		rd_lo_b_q <= mem_lo[rb];
		rd_hi_a_q <= mem_hi[ra];
		rd_hi_b_q <= mem_hi[rb];
	end

	// payload registers
	always_ff @(posedge clk) begin
		if (wr_en && wr_addr == '0)
			top_q[cmd.heap] <= wr_data;
		unique case (cmd.op)
			DP_LOAD:      v_q <= value;
			DP_PUSH_INIT: begin
				if (cmd.from_v)
					pv_q <= v_q;
				k_q <= cnt_sel[IDX_W-1:0];
			end
			DP_PUSH_CMP:  if (status.up_move) k_q <= parent;
			DP_POP_INIT: begin
				pv_q <= top_q[cmd.heap];
				n_q  <= cnt_m1[IDX_W-1:0];
			end
			DP_POP_LAST: begin
				last_q <= rda;
				k_q    <= '0;
			end
			DP_POP_CMP:   if (status.dn_move) k_q <= child_idx;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q[HEAP_LO] <= '0;
			cnt_q[HEAP_HI] <= '0;
			med_q          <= '0;
			drop_q         <= 1'b0;
		end else begin
			if (cmd.op == DP_PUSH_INIT)
				cnt_q[cmd.heap] <= cnt_sel + 1'b1;
			else if (cmd.op == DP_POP_INIT)
				cnt_q[cmd.heap] <= cnt_m1;
			if (cmd.op == DP_FIN) begin
				med_q  <= med_next;
				drop_q <= cmd.drop;
			end
		end
	end

	assign median_x2 = med_q;
	assign dropped   = drop_q;

`ifndef SYNTH
	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q[HEAP_LO] <= CNT_W'(HEAP_DEPTH) && cnt_q[HEAP_HI] <= CNT_W'(HEAP_DEPTH))
		else $error("heap count beyond depth");
	a_balance: assert property (@(posedge clk) disable iff (!arst_n)
		(cnt_q[HEAP_LO] <= cnt_q[HEAP_HI] + 1'b1) && (cnt_q[HEAP_HI] <= cnt_q[HEAP_LO] + 1'b1))
		else $error("heap sizes drifted apart");
	a_odd_even: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.op == DP_FIN && !cmd.drop && cnt_q[HEAP_LO] != cnt_q[HEAP_HI]) |=> !med_q[0])
		else $error("odd count gave odd doubled median");
`endif
endmodule

### hdl/rmth_ctrl.sv
// ----------------------------------------------------------------------------
// rmth_ctrl: item sequencer
// Picks the heap operations for each item, steps the sift loops and hands
// the result to the output channel.
// ----------------------------------------------------------------------------
module rmth_ctrl (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 sample_valid,
	output logic                 sample_ready,
	output logic                 result_valid,
	input  logic                 result_ready,
	output rmth_pkg::dp_cmd_t    cmd,
	input  rmth_pkg::dp_status_t status
);
	import rmth_pkg::*;

	ctl_state_t state_q, state_d;
	heap_op_t   ops_q [3];
	logic [1:0] nops_q, idx_q;
	logic       med_eq_q, drop_q, out_valid_q;
	heap_op_t   cur;
	logic       op_done, out_free;

	assign cur      = ops_q[idx_q];
	assign out_free = !out_valid_q || result_ready;

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE:     if (sample_valid) state_d = ST_DECIDE;
			ST_DECIDE:   state_d = ST_OP_START;
			ST_OP_START: begin
				if (idx_q == nops_q)
					state_d = ST_FIN;
				else if (!cur.pop)
					state_d = ST_PUSH_RD;
				else if (!status.n_zero)
					state_d = ST_POP_LAST;
			end
			ST_PUSH_RD:  state_d = status.k_zero ? ST_OP_START : ST_PUSH_CMP;
			ST_PUSH_CMP: state_d = status.up_move ? ST_PUSH_RD : ST_OP_START;
			ST_POP_LAST: state_d = ST_POP_RD;
			ST_POP_RD:   state_d = status.c_out ? ST_OP_START : ST_POP_CMP;
			ST_POP_CMP:  state_d = status.dn_move ? ST_POP_RD : ST_OP_START;
			ST_FIN:      if (out_free) state_d = ST_IDLE;
			default:     state_d = ST_IDLE;
		endcase
	end

	// outputs
	always_comb begin
		cmd.op     = DP_NOP;
		cmd.heap   = cur.heap;
		cmd.from_v = cur.from_v;
		cmd.med_eq = med_eq_q;
		cmd.drop   = drop_q;
		op_done    = 1'b0;
		unique case (state_q)
			ST_IDLE:     if (sample_valid) cmd.op = DP_LOAD;
			ST_OP_START: begin
				if (idx_q != nops_q) begin
					cmd.op  = cur.pop ? DP_POP_INIT : DP_PUSH_INIT;
					op_done = cur.pop && status.n_zero;
				end
			end
			ST_PUSH_RD: begin
				cmd.op  = DP_PUSH_RD;
				op_done = status.k_zero;
			end
			ST_PUSH_CMP: begin
				cmd.op  = DP_PUSH_CMP;
				op_done = !status.up_move;
			end
			ST_POP_LAST: cmd.op = DP_POP_LAST;
			ST_POP_RD: begin
				cmd.op  = DP_POP_RD;
				op_done = status.c_out;
			end
			ST_POP_CMP: begin
				cmd.op  = DP_POP_CMP;
				op_done = !status.dn_move;
			end
			ST_FIN: begin
				cmd.heap = ops_q[0].heap;
				if (out_free)
					cmd.op = DP_FIN;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			nops_q      <= '0;
			idx_q       <= '0;
			med_eq_q    <= 1'b0;
			drop_q      <= 1'b0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++)
				ops_q[i] <= '0;
		end else begin
			state_q <= state_d;
			if (op_done)
				idx_q <= idx_q + 1'b1;
			if (state_q == ST_DECIDE) begin
				idx_q    <= '0;
				med_eq_q <= status.cnt_eq;
				drop_q   <= status.full;
				if (status.full) begin
					nops_q <= 2'd0;
				end else if (status.cnt_eq || (status.lo_gt && status.above) ||
						(!status.lo_gt && !status.above)) begin
					// single insert, no rebalance
					nops_q   <= 2'd1;
					ops_q[0] <= '{pop: 1'b0, heap: status.above, from_v: 1'b1};
				end else begin
					// move the larger heap's top across, then insert
					nops_q   <= 2'd3;
					ops_q[0] <= '{pop: 1'b1, heap: status.above, from_v: 1'b0};
					ops_q[1] <= '{pop: 1'b0, heap: !status.above, from_v: 1'b0};
					ops_q[2] <= '{pop: 1'b0, heap: status.above, from_v: 1'b1};
				end
			end
			if (state_q == ST_FIN && out_free)
				out_valid_q <= 1'b1;
			else if (result_ready)
				out_valid_q <= 1'b0;
		end
	end

	assign sample_ready = state_q == ST_IDLE;
	assign result_valid = out_valid_q;

`ifndef SYNTH
	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= nops_q)
		else $error("plan index past plan length");
	a_drop_no_ops: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN && drop_q) |-> nops_q == 2'd0)
		else $error("dropped item ran heap operations");
	a_fin_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_FIN) |-> idx_q == nops_q)
		else $error("result issued before plan finished");
`endif
endmodule

### verif/running_median_two_heaps_tb.sv
// ----------------------------------------------------------------------------
// running_median_two_heaps_tb: self-checking bench for the running median
// Streams signed samples through the valid/ready channels and predicts each
// doubled median with a two-heap model of its own. It covers the extreme
// values, every size case of the rebalance, random content under several
// idling patterns, and the filled-heap drop behavior.
// ----------------------------------------------------------------------------
module running_median_two_heaps_tb;
	import rmth_pkg::*;

	logic clk;
	logic arst_n;

	rmth_sample_if sample_ch();
	rmth_result_if result_ch();

	running_median_two_heaps u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.sample (sample_ch),
		.result (result_ch)
	);

	typedef struct {
		med_t median_x2;
		logic dropped;
	} median_result_t;

	// predictor state
	value_t lower_keep [HEAP_DEPTH];
	value_t upper_keep [HEAP_DEPTH];
	int     lower_n;
	int     upper_n;
	longint median_dbl;

	median_result_t pending_medians[$];
	int             idle_pct;
	int             stall_pct;
	int             mismatches;
	int             kept_seen;
	int             drops_seen;
	value_t         last_sent;

	always begin
		clk = 1'b1;
		#1;
		clk = 1'b0;
		#1;
	end

	function automatic bit ranks_above(bit upper, value_t a, value_t b);
		return upper ? (a < b) : (a > b);
	endfunction

	function automatic value_t heap_rd(bit upper, int k);
		return upper ? upper_keep[k] : lower_keep[k];
	endfunction

	function automatic void heap_wr(bit upper, int k, value_t v);
		if (upper) begin
			upper_keep[k] = v;
		end else begin
			lower_keep[k] = v;
		end
	endfunction

	function automatic void heap_push(bit upper, value_t v);
		int k;
		int p;
		k = upper ? upper_n : lower_n;
		if (upper) begin
			upper_n++;
		end else begin
			lower_n++;
		end
		while (k > 0) begin
			p = (k - 1) / 2;
			if (!ranks_above(upper, v, heap_rd(upper, p)))
				break;
			heap_wr(upper, k, heap_rd(upper, p));
			k = p;
		end
		heap_wr(upper, k, v);
	endfunction

	function automatic value_t heap_pop(bit upper);
		value_t top;
		value_t last;
		int     n;
		int     k;
		int     c;
		top = heap_rd(upper, 0);
		n = (upper ? upper_n : lower_n) - 1;
		if (upper) begin
			upper_n = n;
		end else begin
			lower_n = n;
		end
		if (n == 0)
			return top;
		last = heap_rd(upper, n);
		k = 0;
		forever begin
			c = 2 * k + 1;
			if (c >= n)
				break;
			if (c + 1 < n && ranks_above(upper, heap_rd(upper, c + 1), heap_rd(upper, c)))
				c++;
			if (!ranks_above(upper, heap_rd(upper, c), last))
				break;
			heap_wr(upper, k, heap_rd(upper, c));
			k = c;
		end
		heap_wr(upper, k, last);
		return top;
	endfunction

	function automatic median_result_t predict_median(value_t v);
		median_result_t r;
		bit             above;
		value_t         moved;
		above = (2 * longint'(v)) > median_dbl;
		r.dropped = 1'b0;
		if (lower_n >= HEAP_DEPTH && upper_n >= HEAP_DEPTH) begin
			r.dropped = 1'b1;
		end else if (lower_n == upper_n) begin
			heap_push(above, v);
			median_dbl = 2 * longint'(heap_rd(above, 0));
		end else begin
			// move the top of the larger heap when the sample lands on its side
			if (lower_n > upper_n && !above) begin
				moved = heap_pop(1'b0);
				heap_push(1'b1, moved);
			end else if (upper_n > lower_n && above) begin
				moved = heap_pop(1'b1);
				heap_push(1'b0, moved);
			end
			heap_push(above, v);
			median_dbl = longint'(lower_keep[0]) + longint'(upper_keep[0]);
		end
		r.median_x2 = med_t'(median_dbl);
		return r;
	endfunction

	task automatic send_sample(value_t v);
		while ($urandom_range(99) < idle_pct) begin
			@(negedge clk);
			sample_ch.valid = 1'b0;
		end
		@(negedge clk);
		sample_ch.valid = 1'b1;
		sample_ch.value = v;
		do
			@(posedge clk);
		while (!sample_ch.ready);
		pending_medians.insert(pending_medians.size(), predict_median(v));
		last_sent = v;
	endtask

	task automatic end_stream();
		@(negedge clk);
		sample_ch.valid = 1'b0;
	endtask

	// random sample: partly near the running median, with uniform, small, shifted, extreme and repeated values
	function automatic value_t pick_sample();
		longint m;
		m = median_dbl / 2;
		case ($urandom_range(9))
			0, 1, 2: return value_t'($urandom);
			3, 4, 5: return value_t'(m + longint'($urandom_range(64)) - 32);
			6:       return value_t'($urandom_range(15)) - 8;
			7:       return last_sent;
			8:       return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
			default: return value_t'($urandom) >>> $urandom_range(31);
		endcase
	endfunction

	always @(negedge clk) begin
		result_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	always @(posedge clk) begin
		median_result_t want;
		if (result_ch.valid && result_ch.ready) begin
			if (pending_medians.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: median_x2=%0d dropped=%0b",
						result_ch.median_x2, result_ch.dropped);
			end else begin
				want = pending_medians.pop_front();
				if (result_ch.dropped)
					drops_seen++;
				else
					kept_seen++;
				if (result_ch.median_x2 !== want.median_x2 ||
						result_ch.dropped !== want.dropped) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: median_x2 exp %0d got %0d, dropped exp %0b got %0b",
							want.median_x2, result_ch.median_x2, want.dropped,
							result_ch.dropped);
				end
			end
		end
	end

	task automatic test_directed();
		value_t seq[$];
		idle_pct = 0;
		stall_pct = 0;
		// cover equal, lower-larger and upper-larger cases on both sides
		seq = '{32'sd0, 32'sd0, 32'sd5, -32'sd5, 32'sh7fffffff, 32'sh80000000,
			32'sh80000000, 32'sh7fffffff, -32'sd1, 32'sd1, 32'sd3, 32'sd3,
			32'sd2, 32'sh7fffffff, 32'sh7ffffffe, 32'sh80000001, 32'sd0,
			-32'sd7, 32'sd100, 32'sh55555555, 32'shaaaaaaaa};
		foreach (seq[i])
			send_sample(seq[i]);
	endtask

	task automatic test_random(int idle, int stall, int count);
		idle_pct = idle;
		stall_pct = stall;
		repeat (count)
			send_sample(pick_sample());
	endtask

	// fill both heaps, then every further sample is dropped
	task automatic test_overflow(int count);
		for (int i = 0; i < count; i++) begin
			idle_pct = (i % 200 < 100) ? 0 : 83;
			stall_pct = (i % 300 < 150) ? 25 : 83;
			send_sample(pick_sample());
		end
	endtask

	initial begin
		arst_n = 1'b0;
		sample_ch.valid = 1'b0;
		sample_ch.value = '0;
		result_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		mismatches = 0;
		kept_seen = 0;
		drops_seen = 0;
		last_sent = '0;
		lower_n = 0;
		upper_n = 0;
		median_dbl = 0;
		repeat (7)
			@(negedge clk);
		arst_n = 1'b1;

		test_directed();
		test_random(0, 0, 250);
		test_random(83, 0, 250);
		test_random(0, 83, 250);
		test_random(25, 25, 250);
		test_overflow(830);
		end_stream();

		while (pending_medians.size() != 0)
			@(posedge clk);
		repeat (80)
			@(posedge clk);
		if (pending_medians.size() != 0)
			mismatches++;

		$display("Streamed %0d kept and %0d dropped samples through both heaps;",
			kept_seen, drops_seen);
		$display("%0d mismatches across the idle and stall patterns.", mismatches);
		if (mismatches == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

	initial begin
		#4000000;
		$display("Verification failed");
		$finish;
	end

endmodule

### sim.f
hdl/rmth_pkg.sv
hdl/rmth_sample_if.sv
hdl/rmth_result_if.sv
hdl/rmth_dp.sv
hdl/rmth_ctrl.sv
hdl/running_median_two_heaps.sv
verif/running_median_two_heaps_tb.sv
